/* rtl/plt_pkg.sv */
// ----------------------------------------------------------------------------
// plt_pkg: shared types and constants of the positional list table
// Command codes, stream word layout and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package plt_pkg;

  // default number of list entries
  localparam int unsigned CAPACITY_DEF = 16;

  // field widths of the stream words
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned PAY_W      = 32;
  localparam int unsigned CNT_OUT_W  = 5;
  localparam int unsigned FPOS_OUT_W = 4;

  // input word: position, entry_id, entry_payload, padded to bytes
  localparam int unsigned IN_FIELDS_W = POS_W + ID_W + PAY_W;
  localparam int unsigned IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  // output word: count, read_id, read_payload, found_position, padded to bytes
  localparam int unsigned OUT_FIELDS_W = CNT_OUT_W + ID_W + PAY_W + FPOS_OUT_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // command codes; code seven is unused and rejected
  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_AT    = 3'd1,
    CMD_INS_BACK  = 3'd2,
    CMD_REMOVE    = 3'd3,
    CMD_COUNT     = 3'd4,
    CMD_READ      = 3'd5,
    CMD_FIND      = 3'd6
  } plt_cmd_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the accepted word, clear the scan index
    logic scan_inc;  // step the find scan to the next entry
    logic finish;    // commit the command and load the result register
  } plt_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic is_find;   // captured command is a find
    logic scan_done; // find scan has a hit or reached the last entry
    logic out_free;  // result register can take a new word
  } plt_stat_t;

endpackage

`default_nettype wire

/* rtl/plt_ctrl.sv */
// ----------------------------------------------------------------------------
// plt_ctrl: command sequencer of the positional list table
// Accepts one word at a time, runs the find scan and triggers the commit.
// ----------------------------------------------------------------------------
`default_nettype none

module plt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_tvalid_i,
  output logic                   s_tready_o,
  input  plt_pkg::plt_stat_t     stat_i,
  output plt_pkg::plt_ctrl_t     ctrl_o
);

  import plt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_e;

  state_e state_q;
  logic   rdy_q;

  // command strobes
  always_comb begin
    ctrl_o.load     = (state_q == ST_IDLE) && s_tvalid_i && rdy_q;
    ctrl_o.scan_inc = (state_q == ST_SCAN) && !stat_i.scan_done;
    ctrl_o.finish   = stat_i.out_free &&
                      (((state_q == ST_EXEC) && !stat_i.is_find) ||
                       ((state_q == ST_SCAN) && stat_i.scan_done));
  end

  assign s_tready_o = rdy_q;

  // state and ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rdy_q   <= 1'b1;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (s_tvalid_i && rdy_q) begin
            state_q <= ST_EXEC;
            rdy_q   <= 1'b0;
          end
        end
        ST_EXEC: begin
          if (stat_i.is_find) begin
            state_q <= ST_SCAN;
          end else if (stat_i.out_free) begin
            state_q <= ST_IDLE;
            rdy_q   <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (stat_i.scan_done && stat_i.out_free) begin
            state_q <= ST_IDLE;
            rdy_q   <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          rdy_q   <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/plt_datapath.sv */
// ----------------------------------------------------------------------------
// plt_datapath: entry cells, count, find scan and result register
// Cells shift by one place on insert or remove; find walks one entry a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module plt_datapath #(
  parameter int unsigned CAPACITY = plt_pkg::CAPACITY_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [plt_pkg::IN_DATA_W-1:0]  s_tdata_i,
  input  wire logic [plt_pkg::CMD_W-1:0]      s_tuser_i,
  input  plt_pkg::plt_ctrl_t                  ctrl_i,
  output plt_pkg::plt_stat_t                  stat_o,
  input  wire logic                           m_tready_i,
  output logic                                m_tvalid_o,
  output logic [plt_pkg::OUT_DATA_W-1:0]      m_tdata_o,
  output logic                                m_tuser_o
);

  import plt_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned IW = $clog2(CAPACITY);

  // captured command word
  plt_cmd_e          cmd_q;
  logic [POS_W-1:0]  pos_q;
  logic [ID_W-1:0]   id_q;
  logic [PAY_W-1:0]  pay_q;

  // list state
  logic [ID_W-1:0]   cell_id_q  [CAPACITY];
  logic [PAY_W-1:0]  cell_pay_q [CAPACITY];
  logic [CW-1:0]     cnt_q;
  logic [CW-1:0]     cnt_d;
  logic [IW-1:0]     scan_q;

  // result register
  logic              m_valid_q;
  logic              ok_q;
  logic [CNT_OUT_W-1:0]  cnt_out_q;
  logic [ID_W-1:0]   rid_q;
  logic [PAY_W-1:0]  rpay_q;
  logic [FPOS_OUT_W-1:0] fpos_q;

  logic [PW-1:0]     pos_ext;
  logic [PW-1:0]     cnt_ext;
  logic [PW-1:0]     ins_pos;
  logic              full;
  logic              ins_ok;
  logic              rem_ok;
  logic              rd_ok;
  logic              ins_en;
  logic              rem_en;
  logic [IW-1:0]     rd_idx;
  logic [ID_W-1:0]   rd_id;
  logic [PAY_W-1:0]  rd_pay;
  logic              scan_hit;
  logic              scan_last;
  logic              ok_d;
  logic [CW+CNT_OUT_W-1:0]  cnt_wide;
  logic [IW+FPOS_OUT_W-1:0] fpos_wide;

  // capture accepted word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= plt_cmd_e'(s_tuser_i);
      pos_q <= s_tdata_i[POS_W-1:0];
      id_q  <= s_tdata_i[POS_W +: ID_W];
      pay_q <= s_tdata_i[POS_W+ID_W +: PAY_W];
    end
  end

  assign pos_ext = PW'(pos_q);
  assign cnt_ext = PW'(cnt_q);
  assign full    = (cnt_q >= CW'(CAPACITY));

  // bounds checks and insert slot
  always_comb begin
    ins_ok  = 1'b0;
    rem_ok  = 1'b0;
    rd_ok   = 1'b0;
    ins_pos = '0;
    case (cmd_q)
      CMD_INS_FRONT: begin
        ins_ok  = !full;
        ins_pos = '0;
      end
      CMD_INS_AT: begin
        ins_ok  = !full && (pos_ext <= cnt_ext);
        ins_pos = pos_ext;
      end
      CMD_INS_BACK: begin
        ins_ok  = !full;
        ins_pos = cnt_ext;
      end
      CMD_REMOVE: rem_ok = (pos_ext < cnt_ext);
      CMD_READ:   rd_ok  = (pos_ext < cnt_ext);
      default: ;
    endcase
  end

  assign ins_en = ctrl_i.finish && ins_ok;
  assign rem_en = ctrl_i.finish && rem_ok;

  // single read port shared by read and find
  assign rd_idx = (cmd_q == CMD_FIND) ? scan_q : pos_ext[IW-1:0];
  assign rd_id  = cell_id_q[rd_idx];
  assign rd_pay = cell_pay_q[rd_idx];

  // find scan
  assign scan_hit  = (CW'(scan_q) < cnt_q) && (rd_id == id_q);
  assign scan_last = ((CW'(scan_q) + CW'(1)) >= cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else if (ctrl_i.load) begin
      scan_q <= '0;
    end else if (ctrl_i.scan_inc) begin
      scan_q <= scan_q + IW'(1);
    end
  end

  always_comb begin
    stat_o.is_find   = (cmd_q == CMD_FIND);
    stat_o.scan_done = scan_hit || scan_last;
    stat_o.out_free  = !m_valid_q || m_tready_i;
  end

  // entry cells: each takes its left or right neighbor on a shift
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    localparam logic [PW-1:0] KP = PW'(k);
    logic [ID_W-1:0]  left_id;
    logic [PAY_W-1:0] left_pay;
    logic [ID_W-1:0]  right_id;
    logic [PAY_W-1:0] right_pay;

    if (k == 0) begin : g_head
      assign left_id  = id_q;
      assign left_pay = pay_q;
    end else begin : g_body
      assign left_id  = cell_id_q[k-1];
      assign left_pay = cell_pay_q[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign right_id  = cell_id_q[k];
      assign right_pay = cell_pay_q[k];
    end else begin : g_next
      assign right_id  = cell_id_q[k+1];
      assign right_pay = cell_pay_q[k+1];
    end

    always_ff @(posedge clk_i) begin
      if (ins_en) begin
        if (KP == ins_pos) begin
          cell_id_q[k]  <= id_q;
          cell_pay_q[k] <= pay_q;
        end else if (KP > ins_pos) begin
          cell_id_q[k]  <= left_id;
          cell_pay_q[k] <= left_pay;
        end
      end else if (rem_en && (KP >= pos_ext)) begin
        cell_id_q[k]  <= right_id;
        cell_pay_q[k] <= right_pay;
      end
    end
  end

  // entry count
  always_comb begin
    cnt_d = cnt_q;
    if (ins_en) begin
      cnt_d = cnt_q + CW'(1);
    end else if (rem_en) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // result fields
  always_comb begin
    case (cmd_q)
      CMD_INS_FRONT, CMD_INS_AT, CMD_INS_BACK: ok_d = ins_ok;
      CMD_REMOVE: ok_d = rem_ok;
      CMD_COUNT:  ok_d = 1'b1;
      CMD_READ:   ok_d = rd_ok;
      CMD_FIND:   ok_d = scan_hit;
      default:    ok_d = 1'b0;
    endcase
  end

  assign cnt_wide  = {{CNT_OUT_W{1'b0}}, cnt_d};
  assign fpos_wide = {{FPOS_OUT_W{1'b0}}, scan_q};

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctrl_i.finish) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish) begin
      ok_q      <= ok_d;
      cnt_out_q <= cnt_wide[CNT_OUT_W-1:0];
      rid_q     <= rd_ok ? rd_id : '0;
      rpay_q    <= rd_ok ? rd_pay : '0;
      fpos_q    <= scan_hit ? fpos_wide[FPOS_OUT_W-1:0] : '0;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tuser_o  = ok_q;
  assign m_tdata_o  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
                       fpos_q, rpay_q, rid_q, cnt_out_q};

endmodule

`default_nettype wire

/* rtl/positional_list_table.sv */
// ----------------------------------------------------------------------------
// positional_list_table: bounded ordered list of (id, payload) entries
// Insert at front, position or back, remove, count, read and find by id.
//
//   channel  dir  handshake                    tdata (low bit up)            tuser
//   s_axis   in   s_axis_tvalid/s_axis_tready  position, entry_id, payload   cmd
//   m_axis   out  m_axis_tvalid/m_axis_tready  count, read_id, read_payload, ok
//                                              found_position
//
// One word is worked on at a time. Insert, remove, count and read commit
// from the captured word; find first scans the entries until a hit or the
// last entry (one compare a cycle on the single read port).
// A result waits in an output register; the next word is taken only after the
// previous result has been loaded there. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_table #(
  parameter int unsigned CAPACITY = plt_pkg::CAPACITY_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // position[4:0], entry_id[36:5], entry_payload[68:37], zero pad
  input  wire logic [plt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // cmd[2:0]
  input  wire logic [plt_pkg::CMD_W-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // count[4:0], read_id[36:5], read_payload[68:37], found_position[72:69], pad
  output logic [plt_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // ok[0]
  output logic                                m_axis_tuser
);

  import plt_pkg::*;

  plt_ctrl_t ctrl;
  plt_stat_t stat;

  // sequencer
  plt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // list storage and result register
  plt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

/* tb/tb_positional_list_table.sv */
// ----------------------------------------------------------------------------
// tb_positional_list_table: self-checking bench for the positional list table
// Drives commands into the stream input and keeps a shadow copy of the list.
// Every result word is compared field by field, in order, with the shadow
// list's answer. Directed cases run first: empty list, insert positions and
// a full list. Random traffic follows under three source and sink idle mixes.
// ----------------------------------------------------------------------------
module tb_positional_list_table;
  import plt_pkg::*;

  localparam int unsigned LIST_DEPTH = CAPACITY_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  // bit offsets inside the stream words
  localparam int unsigned OUT_RID_LSB = CNT_OUT_W;
  localparam int unsigned OUT_PAY_LSB = CNT_OUT_W + ID_W;
  localparam int unsigned OUT_FP_LSB  = CNT_OUT_W + ID_W + PAY_W;

  typedef struct packed {
    logic                  ok;
    logic [CNT_OUT_W-1:0]  count;
    logic [ID_W-1:0]       read_id;
    logic [PAY_W-1:0]      read_payload;
    logic [FPOS_OUT_W-1:0] found_position;
  } list_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // position, entry_id, entry_payload, zero pad
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  // cmd
  logic [CMD_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // count, read_id, read_payload, found_position, zero pad
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // ok
  logic                  m_axis_tuser;

  // shadow list and pending answers
  logic [ID_W-1:0]  shadow_ids [LIST_DEPTH];
  logic [PAY_W-1:0] shadow_payloads [LIST_DEPTH];
  int unsigned      shadow_count = 0;
  list_result_t     pending_results [$];

  int unsigned error_count   = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  list_result_t want_word;
  list_result_t seen_word;

  positional_list_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // sink stalls
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // apply one command to the shadow list and return its answer
  function automatic list_result_t apply_list_command(input logic [CMD_W-1:0] cmd,
                                                      input logic [POS_W-1:0] pos,
                                                      input logic [ID_W-1:0]  id,
                                                      input logic [PAY_W-1:0] payload);
    list_result_t res;
    int           slot;
    int           i;
    bit           full;
    res  = '0;
    slot = -1;
    full = (shadow_count >= LIST_DEPTH);
    case (cmd)
      CMD_INS_FRONT: if (!full) slot = 0;
      CMD_INS_AT:    if (!full && pos <= shadow_count) slot = int'(pos);
      CMD_INS_BACK:  if (!full) slot = int'(shadow_count);
      CMD_REMOVE: begin
        if (pos < shadow_count) begin
          for (i = int'(pos); i + 1 < int'(shadow_count); i++) begin
            shadow_ids[i]      = shadow_ids[i+1];
            shadow_payloads[i] = shadow_payloads[i+1];
          end
          shadow_count--;
          res.ok = 1'b1;
        end
      end
      CMD_COUNT: res.ok = 1'b1;
      CMD_READ: begin
        if (pos < shadow_count) begin
          res.read_id      = shadow_ids[pos];
          res.read_payload = shadow_payloads[pos];
          res.ok           = 1'b1;
        end
      end
      CMD_FIND: begin
        // lowest matching position wins
        for (i = 0; i < int'(shadow_count); i++) begin
          if (!res.ok && shadow_ids[i] == id) begin
            res.ok             = 1'b1;
            res.found_position = FPOS_OUT_W'(i);
          end
        end
      end
      default: ;
    endcase
    // open a gap for an accepted insert
    if (slot >= 0) begin
      for (i = int'(shadow_count); i > slot; i--) begin
        shadow_ids[i]      = shadow_ids[i-1];
        shadow_payloads[i] = shadow_payloads[i-1];
      end
      shadow_ids[slot]      = id;
      shadow_payloads[slot] = payload;
      shadow_count++;
      res.ok = 1'b1;
    end
    res.count = CNT_OUT_W'(shadow_count);
    return res;
  endfunction

  // send one command word, with optional idle cycles ahead of it
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic [ID_W-1:0] id, input logic [PAY_W-1:0] payload);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({payload, id, pos});
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(apply_list_command(cmd, pos, id, payload));
  endtask

  // stop sending until every answer is back
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic flag_field(input string name, input logic [63:0] want,
                            input logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_word.ok             = m_axis_tuser;
      seen_word.count          = m_axis_tdata[CNT_OUT_W-1:0];
      seen_word.read_id        = m_axis_tdata[OUT_RID_LSB +: ID_W];
      seen_word.read_payload   = m_axis_tdata[OUT_PAY_LSB +: PAY_W];
      seen_word.found_position = m_axis_tdata[OUT_FP_LSB +: FPOS_OUT_W];
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result word, expected none, actual %h", $time, seen_word);
      end else begin
        want_word = pending_results.pop_front();
        flag_field("ok", want_word.ok, seen_word.ok);
        flag_field("count", want_word.count, seen_word.count);
        flag_field("read_id", want_word.read_id, seen_word.read_id);
        flag_field("read_payload", want_word.read_payload, seen_word.read_payload);
        flag_field("found_position", want_word.found_position, seen_word.found_position);
      end
    end
  end

  // remove, read and find rejections on an empty list, plus the unused code
  task automatic test_empty_list();
    send_word(CMD_REMOVE, 5'd0, 32'h0, 32'h0);
    send_word(CMD_READ, 5'd0, 32'h0, 32'h0);
    send_word(CMD_FIND, 5'd0, 32'h0, 32'h0);
    send_word(CMD_UNUSED, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // each insert kind, a position past the count and an append by position
  task automatic test_insert_positions();
    send_word(CMD_INS_BACK, 5'd31, 32'h7FFF_FFFF, 32'h0000_0000);
    send_word(CMD_INS_FRONT, 5'd0, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(CMD_INS_AT, 5'd1, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
    send_word(CMD_INS_AT, 5'd4, 32'h1234_5678, 32'h0BAD_F00D);
    send_word(CMD_INS_AT, 5'd3, 32'h0000_0000, 32'hA5A5_5A5A);
  endtask

  // fill to capacity with repeated ids, then hit the full and range limits
  task automatic test_full_list();
    int unsigned k;
    for (k = 0; k < LIST_DEPTH - 4; k++) begin
      send_word(CMD_INS_AT, POS_W'((k * 3) % (shadow_count + 1)), ID_W'(k % 3), $urandom);
    end
    send_word(CMD_INS_AT, 5'd16, 32'h0000_0009, 32'h0);
    send_word(CMD_READ, 5'd15, 32'h0, 32'h0);
    send_word(CMD_FIND, 5'd0, 32'h0000_0002, 32'h0);
    send_word(CMD_REMOVE, 5'd16, 32'h0, 32'h0);
    send_word(CMD_REMOVE, 5'd0, 32'h0, 32'h0);
    send_word(CMD_COUNT, 5'd0, 32'h0, 32'h0);
  endtask

  // random list traffic; the insert share drifts so the list fills and drains
  task automatic test_random_traffic(input int unsigned words);
    int unsigned      n;
    int unsigned      roll;
    int unsigned      fill_bias;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic [ID_W-1:0]  id;
    logic [PAY_W-1:0] payload;
    plt_cmd_e         inserts [3];
    plt_cmd_e         queries [4];
    inserts   = '{CMD_INS_FRONT, CMD_INS_AT, CMD_INS_BACK};
    queries   = '{CMD_REMOVE, CMD_READ, CMD_FIND, CMD_COUNT};
    fill_bias = 50;
    for (n = 0; n < words; n++) begin
      if (n % 50 == 0) fill_bias = $urandom_range(75, 10);
      roll    = $urandom_range(99);
      payload = $urandom;
      // small id pool so finds hit and ids repeat
      if ($urandom_range(1) != 0) id = $urandom;
      else if ($urandom_range(1) != 0) id = ID_W'($urandom_range(7));
      else id = -ID_W'($urandom_range(8, 1));
      if (roll < fill_bias) begin
        cmd = inserts[$urandom_range(2)];
        pos = POS_W'($urandom_range(shadow_count));
      end else if (roll < 90) begin
        cmd = queries[$urandom_range(3)];
        pos = (shadow_count != 0) ? POS_W'($urandom_range(shadow_count - 1)) : '0;
        if (cmd == CMD_FIND && shadow_count != 0 && $urandom_range(99) < 60) begin
          id = shadow_ids[$urandom_range(shadow_count - 1)];
        end
      end else begin
        // noise: any code, any position
        cmd = CMD_W'($urandom);
        pos = POS_W'($urandom);
      end
      send_word(cmd, pos, id, payload);
      if ($urandom_range(99) < 2) hold_until_drained();
    end
  endtask

  // test sequence
  initial begin
    src_idle_pct  = 28;
    snk_stall_pct = 57;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_list();
    test_insert_positions();
    test_full_list();
    hold_until_drained();
    test_random_traffic(250);
    hold_until_drained();
    src_idle_pct  = 57;
    snk_stall_pct = 28;
    test_random_traffic(250);
    hold_until_drained();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    test_random_traffic(250);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
rtl/plt_pkg.sv
rtl/plt_ctrl.sv
rtl/plt_datapath.sv
rtl/positional_list_table.sv
tb/tb_positional_list_table.sv
